FILE: rtl/tmtw_pkg.sv
// Shared types and constants for the text-mode terminal writer.
`timescale 1ns / 1ps
package tmtw_pkg;

	// Operation codes carried by each input transaction
	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_SET   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// Character codes with special meaning
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Tab stops every four columns
	localparam int unsigned TAB_STEP = 4;

	// Cell value written by the power-on clearing pass
	localparam logic [15:0] RESET_CELL = 16'h0720;

	// Cursor storage: wide enough for 64 rows and 128 columns
	typedef logic [5:0] row_t;
	typedef logic [6:0] col_t;

	// Cursor update handed from the cursor unit to the sequencer
	typedef struct packed {
		row_t row;
		col_t col;
		logic wr_char;
		logic scroll;
	} cur_upd_t;

endpackage

FILE: rtl/tmtw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tmtw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/tmtw_cursor.sv
// Next-cursor logic for put character, set cursor and clear operations.
`timescale 1ns / 1ps
module tmtw_cursor #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic [1:0]         operation,
	input  logic [7:0]         char_code,
	input  logic [4:0]         new_row,
	input  logic [6:0]         new_col,
	input  tmtw_pkg::row_t     row,
	input  tmtw_pkg::col_t     col,
	output tmtw_pkg::cur_upd_t upd
);
	import tmtw_pkg::*;

	logic [6:0] row_inc;
	logic [7:0] col_inc;
	logic [7:0] col_tab;
	logic [6:0] row_nx;
	col_t       col_nx;
	logic       printable;

	assign row_inc   = {1'b0, row} + 7'd1;
	assign col_inc   = {1'b0, col} + 8'd1;
	assign col_tab   = ({1'b0, col} + 8'(TAB_STEP)) & ~8'(TAB_STEP - 1);
	assign printable = !char_code[7] && (char_code >= CHAR_SPACE);

	// Advance the cursor for one character byte
	always_comb begin
		row_nx = {1'b0, row};
		col_nx = col;
		if (char_code == CHAR_NL) begin
			col_nx = '0;
			row_nx = row_inc;
		end else if (char_code == CHAR_CR) begin
			col_nx = '0;
		end else if (char_code == CHAR_TAB) begin
			if (32'(col_tab) >= 32'(COLUMNS)) begin
				col_nx = '0;
				row_nx = row_inc;
			end else begin
				col_nx = col_t'(col_tab);
			end
		end else if (printable) begin
			if (32'(col_inc) >= 32'(COLUMNS)) begin
				col_nx = '0;
				row_nx = row_inc;
			end else begin
				col_nx = col_t'(col_inc);
			end
		end
	end

	// Select the update for the operation
	always_comb begin
		upd = '{row: row, col: col, wr_char: 1'b0, scroll: 1'b0};
		case (op_t'(operation))
			OP_PUT: begin
				upd.wr_char = printable;
				if (32'(row_nx) >= 32'(ROWS)) begin
					upd.row    = row_t'(ROWS - 1);
					upd.col    = '0;
					upd.scroll = 1'b1;
				end else begin
					upd.row = row_t'(row_nx);
					upd.col = col_nx;
				end
			end
			OP_CLEAR: begin
				upd.row = '0;
				upd.col = '0;
			end
			OP_SET: begin
				upd.row = (32'(new_row) >= 32'(ROWS)) ? row_t'(ROWS - 1) : row_t'(new_row);
				upd.col = (32'(new_col) >= 32'(COLUMNS)) ? col_t'(COLUMNS - 1)
					: col_t'(new_col);
			end
			default: begin
				upd.row = row;
			end
		endcase
	end

endmodule

FILE: rtl/text_mode_terminal_writer.sv
// Top level: cell store, cursor registers and the sweep sequencer of the terminal writer.
// out_valid rises when S_RESP registers the result: put character and set cursor pass
// S_EXEC, read cell S_EXEC and S_READ, a put that scrolls S_EXEC, S_SCR_RD and an S_SCROLL
// sweep, clear S_EXEC and an S_FILL sweep. One transaction at a time: the next is taken
// only once the result is registered and the sequencer is back in S_IDLE; an untaken
// result holds the sequencer. Reset: cursor homes, color returns to 7, then a clearing
// pass over all ROWS*COLUMNS cells fills every cell with 0x0720 while in_ready stays low.
`timescale 1ns / 1ps
module text_mode_terminal_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  char_code,
	input  logic [4:0]  new_row,
	input  logic [6:0]  new_col,
	input  logic [10:0] cell_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] cell_data,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic        scrolled
);
	import tmtw_pkg::*;

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int LAST_BASE  = CELL_COUNT - COLUMNS;

	typedef enum logic [6:0] {
		S_FILL    = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_EXEC    = 7'b0000100,
		S_SCR_RD  = 7'b0001000,
		S_SCROLL  = 7'b0010000,
		S_READ    = 7'b0100000,
		S_RESP    = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [7:0]        color_q;
	row_t              row_q;
	col_t              col_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [15:0]       fill_q;
	logic              fill_resp_q;
	logic              scr_q;
	logic [15:0]       rdat_q;
	logic [1:0]        op_q;
	logic [7:0]        char_q;
	logic [4:0]        nrow_q;
	logic [6:0]        ncol_q;
	logic [10:0]       idx_q;

	logic              out_valid_q;
	logic [15:0]       cell_data_q;
	logic [4:0]        cursor_row_q;
	logic [6:0]        cursor_col_q;
	logic              scrolled_q;

	cur_upd_t          upd;
	logic [15:0]       blank;
	logic              cnt_last;
	logic              in_range;
	logic [31:0]       scr_rd_nx;
	logic              out_load;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	tmtw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_cursor (
		.operation(op_q),
		.char_code(char_q),
		.new_row  (nrow_q),
		.new_col  (ncol_q),
		.row      (row_q),
		.col      (col_q),
		.upd      (upd)
	);

	tmtw_ram #(
		.WIDTH(16),
		.DEPTH(CELL_COUNT)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign blank     = {color_q, CHAR_SPACE};
	assign cnt_last  = (32'(cnt_q) == 32'(CELL_COUNT - 1));
	assign in_range  = (32'(idx_q) < 32'(CELL_COUNT));
	assign scr_rd_nx = 32'(cnt_q) + 32'(COLUMNS) + 32'd1;
	assign out_load  = (state_q == S_RESP) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);

	// Steer the RAM ports by sequencer state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = fill_q;
		ram_re    = 1'b0;
		ram_raddr = ADDR_W'(idx_q);
		case (state_q)
			S_FILL: begin
				ram_we = 1'b1;
			end
			S_EXEC: begin
				if (op_t'(op_q) == OP_PUT && upd.wr_char) begin
					ram_we    = 1'b1;
					ram_waddr = ADDR_W'(32'(row_q) * 32'(COLUMNS) + 32'(col_q));
					ram_wdata = {color_q, char_q};
				end
				ram_re = (op_t'(op_q) == OP_READ) && in_range;
			end
			S_SCR_RD: begin
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(COLUMNS);
			end
			S_SCROLL: begin
				ram_we    = 1'b1;
				ram_wdata = (32'(cnt_q) < 32'(LAST_BASE)) ? ram_rdata : blank;
				ram_re    = (scr_rd_nx < 32'(CELL_COUNT));
				ram_raddr = ADDR_W'(scr_rd_nx);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Hold the color register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= 8'd7;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	// Advance the sequencer, cursor and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			fill_q      <= RESET_CELL;
			fill_resp_q <= 1'b0;
			scr_q       <= 1'b0;
			rdat_q      <= '0;
		end else begin
			case (state_q)
				S_FILL: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= fill_resp_q ? S_RESP : S_IDLE;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					scr_q  <= 1'b0;
					rdat_q <= '0;
					row_q  <= upd.row;
					col_q  <= upd.col;
					case (op_t'(op_q))
						OP_PUT: begin
							scr_q   <= upd.scroll;
							state_q <= upd.scroll ? S_SCR_RD : S_RESP;
						end
						OP_CLEAR: begin
							cnt_q       <= '0;
							fill_q      <= blank;
							fill_resp_q <= 1'b1;
							state_q     <= S_FILL;
						end
						OP_READ: begin
							state_q <= S_READ;
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_SCR_RD: begin
					cnt_q   <= '0;
					state_q <= S_SCROLL;
				end
				S_SCROLL: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= S_RESP;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				S_READ: begin
					rdat_q  <= in_range ? ram_rdata : '0;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= operation;
			char_q <= char_code;
			nrow_q <= new_row;
			ncol_q <= new_col;
			idx_q  <= cell_index;
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cell_data_q  <= rdat_q;
			cursor_row_q <= 5'(row_q);
			cursor_col_q <= 7'(col_q);
			scrolled_q   <= scr_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_data  = cell_data_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;
	assign scrolled   = scrolled_q;

endmodule

FILE: test/tmtw_checker.sv
// Screen checker for the text-mode terminal writer: predicts each result and compares it.
`timescale 1ns / 1ps
module tmtw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  char_code,
	input  logic [4:0]  new_row,
	input  logic [6:0]  new_col,
	input  logic [10:0] cell_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] cell_data,
	input  logic [4:0]  cursor_row,
	input  logic [6:0]  cursor_col,
	input  logic        scrolled,
	output int          failures,
	output int          pending
);
	import tmtw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam logic [7:0] PRINT_LAST = 8'h7F;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic [15:0] cell_val;
		logic [4:0]  row;
		logic [6:0]  col;
		logic        scroll;
	} term_result_t;

	// Shadow screen, cursor and color
	logic [15:0]  screen_cells [CELLS];
	int unsigned  cur_row;
	int unsigned  cur_col;
	logic [7:0]   text_color;
	term_result_t predicted_results [$];

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		if (failures < MAX_REPORTS)
			$display("%0t tmtw_checker: %s is %h, predicted %h", $time, what, got, want);
		failures++;
	endtask

	// Shift every line up one and blank the bottom line in the current color
	function automatic void scroll_screen();
		for (int i = 0; i < CELLS - COLUMNS; i++)
			screen_cells[i] = screen_cells[i + COLUMNS];
		for (int i = CELLS - COLUMNS; i < CELLS; i++)
			screen_cells[i] = {text_color, CHAR_SPACE};
	endfunction

	// Write or interpret one byte; return 1 when the screen scrolled
	function automatic bit put_character(logic [7:0] ch);
		if (ch == CHAR_NL) begin
			cur_col = 0;
			cur_row++;
		end else if (ch == CHAR_CR) begin
			cur_col = 0;
		end else if (ch == CHAR_TAB) begin
			cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
			if (cur_col >= COLUMNS) begin
				cur_col = 0;
				cur_row++;
			end
		end else if (ch >= CHAR_SPACE && ch <= PRINT_LAST) begin
			screen_cells[cur_row * COLUMNS + cur_col] = {text_color, ch};
			cur_col++;
			if (cur_col >= COLUMNS) begin
				cur_col = 0;
				cur_row++;
			end
		end
		// Bytes outside the printable range and other control codes fall through untouched
		if (cur_row >= ROWS) begin
			scroll_screen();
			cur_row = ROWS - 1;
			cur_col = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic term_result_t execute_command(op_t op, logic [7:0] ch, logic [4:0] r,
			logic [6:0] c, logic [10:0] idx);
		term_result_t res;
		res = '0;
		case (op)
			OP_PUT: begin
				res.scroll = put_character(ch);
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_cells[i] = {text_color, CHAR_SPACE};
				cur_row = 0;
				cur_col = 0;
			end
			OP_SET: begin
				cur_row = (r >= ROWS) ? ROWS - 1 : r;
				cur_col = (c >= COLUMNS) ? COLUMNS - 1 : c;
			end
			default: begin
				if (idx < CELLS)
					res.cell_val = screen_cells[idx];
			end
		endcase
		res.row = 5'(cur_row);
		res.col = 7'(cur_col);
		return res;
	endfunction

	// Track configuration, check results, queue predictions
	always @(posedge clk or negedge arst_n) begin
		term_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen_cells[i] = RESET_CELL;
			cur_row = 0;
			cur_col = 0;
			text_color = 8'h07;
			predicted_results.delete();
			failures = 0;
		end else begin
			if (cfg_we)
				text_color = cfg_wdata;
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("cell_data of an unrequested transaction", cell_data, '0);
				end else begin
					want = predicted_results.pop_front();
					if (cell_data !== want.cell_val)
						report_mismatch("cell_data", cell_data, want.cell_val);
					if (cursor_row !== want.row)
						report_mismatch("cursor_row", 16'(cursor_row), 16'(want.row));
					if (cursor_col !== want.col)
						report_mismatch("cursor_col", 16'(cursor_col), 16'(want.col));
					if (scrolled !== want.scroll)
						report_mismatch("scrolled", 16'(scrolled), 16'(want.scroll));
				end
			end
			if (in_valid && in_ready)
				predicted_results.push_back(execute_command(op_t'(operation), char_code,
					new_row, new_col, cell_index));
		end
		pending = predicted_results.size();
	end

endmodule

FILE: test/testbench.sv
// Top of the terminal writer testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;
	import tmtw_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 20_000_000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [7:0]  char_code;
	logic [4:0]  new_row;
	logic [6:0]  new_col;
	logic [10:0] cell_index;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] cell_data;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_col;
	logic        scrolled;

	int          mismatch_count;
	int          outstanding;
	int          cycle_count = 0;
	int          hold_requests = 0;
	int          holds_served = 0;
	int unsigned drain_pause = 0;
	bit          sender_gaps = 1'b1;
	bit          receiver_gaps = 1'b1;

	always #5 clk = ~clk;

	text_mode_terminal_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.char_code(char_code),
		.new_row(new_row),
		.new_col(new_col),
		.cell_index(cell_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_data(cell_data),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.scrolled(scrolled)
	);

	tmtw_checker #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.char_code(char_code),
		.new_row(new_row),
		.new_col(new_col),
		.cell_index(cell_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_data(cell_data),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.scrolled(scrolled),
		.failures(mismatch_count),
		.pending(outstanding)
	);

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_cycles(bit enabled);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (!enabled || pick < 55)
			return 0;
		if (pick < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one transaction at a falling edge and hold it until accepted
	task automatic send_item(op_t op, logic [7:0] ch, logic [4:0] r, logic [6:0] c,
			logic [10:0] idx);
		int unsigned gap;
		gap = idle_cycles(sender_gaps);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		char_code  <= ch;
		new_row    <= r;
		new_col    <= c;
		cell_index <= idx;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Drop valid and wait for every predicted result to come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic write_color(logic [7:0] color);
		cfg_we    <= 1'b1;
		cfg_wdata <= color;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Weighted mix: text and line control, cursor moves near the bottom, reads, rare clears
	task automatic random_item();
		int unsigned pick;
		op_t         op;
		logic [7:0]  ch;
		logic [4:0]  r;
		logic [6:0]  c;
		logic [10:0] idx;
		ch   = 8'($urandom);
		r    = 5'($urandom);
		c    = 7'($urandom);
		idx  = 11'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			op   = OP_PUT;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				ch = 8'($urandom_range(32, 127));
			else if (pick < 80)
				ch = CHAR_NL;
			else if (pick < 85)
				ch = CHAR_CR;
			else if (pick < 92)
				ch = CHAR_TAB;
		end else if (pick < 67) begin
			op   = OP_SET;
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				r = 5'($urandom_range(ROWS - 2, ROWS - 1));
				c = 7'($urandom_range(COLUMNS - 8, COLUMNS - 1));
			end else if (pick < 80) begin
				r = 5'($urandom_range(0, ROWS - 1));
				c = 7'($urandom_range(0, COLUMNS - 1));
			end
		end else if (pick < 98) begin
			op   = OP_READ;
			pick = $urandom_range(0, 99);
			if (pick < 30)
				idx = 11'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
			else if (pick < 85)
				idx = 11'($urandom_range(0, CELLS - 1));
			else if (pick < 93)
				idx = 11'($urandom_range(CELLS, 2047));
		end else begin
			op = OP_CLEAR;
		end
		send_item(op, ch, r, c, idx);
	endtask

	// Output side: random stalls, plus a long hold-off whenever one is requested
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				holds_served++;
			end else if (drain_pause > 0) begin
				out_ready <= 1'b0;
				drain_pause--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					drain_pause = idle_cycles(receiver_gaps);
			end
		end
	end

	// Abort a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("text_mode_terminal_writer: mismatch");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		logic [7:0] color;
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_wdata  <= '0;
		in_valid   <= 1'b0;
		operation  <= OP_PUT;
		char_code  <= '0;
		new_row    <= '0;
		new_col    <= '0;
		cell_index <= '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset contents, byte classes, saturation, every scroll path, clear
		send_item(OP_READ, 8'h00, 5'd0, 7'd0, 11'd0);
		send_item(OP_READ, 8'h00, 5'd0, 7'd0, 11'(CELLS - 1));
		send_item(OP_READ, 8'h00, 5'd0, 7'd0, 11'h7FF);
		send_item(OP_PUT, 8'h41, 5'd0, 7'd0, 11'd0);
		send_item(OP_PUT, CHAR_SPACE, 5'd0, 7'd0, 11'd0);
		send_item(OP_PUT, 8'h7F, 5'd0, 7'd0, 11'd0);
		send_item(OP_PUT, 8'h1F, 5'd0, 7'd0, 11'd0);
		send_item(OP_PUT, 8'h80, 5'd0, 7'd0, 11'd0);
		send_item(OP_PUT, 8'hFF, 5'd0, 7'd0, 11'd0);
		send_item(OP_PUT, 8'h00, 5'd0, 7'd0, 11'd0);
		send_item(OP_PUT, CHAR_TAB, 5'd0, 7'd0, 11'd0);
		send_item(OP_PUT, CHAR_NL, 5'd0, 7'd0, 11'd0);
		send_item(OP_PUT, CHAR_CR, 5'd0, 7'd0, 11'd0);
		send_item(OP_READ, 8'h00, 5'd0, 7'd0, 11'd1);
		send_item(OP_SET, 8'h00, 5'h1F, 7'h7F, 11'd0);
		send_item(OP_PUT, 8'h5A, 5'd0, 7'd0, 11'd0);
		send_item(OP_SET, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 2), 11'd0);
		send_item(OP_PUT, CHAR_TAB, 5'd0, 7'd0, 11'd0);
		send_item(OP_SET, 8'h00, 5'(ROWS - 1), 7'd0, 11'd0);
		send_item(OP_PUT, CHAR_NL, 5'd0, 7'd0, 11'd0);
		send_item(OP_READ, 8'h00, 5'd0, 7'd0, 11'(CELLS - COLUMNS - 1));
		send_item(OP_READ, 8'h00, 5'd0, 7'd0, 11'(CELLS - COLUMNS));
		send_item(OP_CLEAR, 8'h00, 5'd0, 7'd0, 11'd0);
		send_item(OP_SET, 8'h00, 5'd0, 7'(COLUMNS - 1), 11'd0);
		send_item(OP_PUT, CHAR_TAB, 5'd0, 7'd0, 11'd0);

		// Random phases, each under its own color and idling mix
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0:       color = 8'h00;
				1:       color = 8'hFF;
				default: color = 8'($urandom);
			endcase
			write_color(color);
			sender_gaps   = (p % 3 != 2);
			receiver_gaps = (p % 3 != 1);
			if (p == 2)
				hold_requests++;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) == 0)
					wait_drained();
				random_item();
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("text_mode_terminal_writer: match");
		else
			$display("text_mode_terminal_writer: mismatch");
		$finish;
	end

endmodule
